// ===== design/dd_pkg.sv =====
// Shared constants, types and helpers for the datagram deframer.
package dd_pkg;

  localparam int WINDOW_BYTES = 64;
  localparam int IDX_W = $clog2(WINDOW_BYTES);
  localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam int TOT_W = 6;
  localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  localparam logic [7:0] DATA_MARK = 8'h80;
  localparam logic [6:0] LOW7 = 7'h7F;
  localparam logic [7:0] LEN_LOW = 8'h07;
  localparam logic [7:0] LEN_HIGH = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_HDR,
    ST_SUM,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_ONE,
    OFF_KNEXT
  } rd_off_t;

  typedef struct packed {
    logic    wr_in;
    logic    rd_en;
    rd_off_t rd_off;
    logic    discard;
    logic    start_sum;
    logic    sum_step;
    logic    accept;
    logic    load;
    logic    finish;
  } dd_cmd_t;

  typedef struct packed {
    logic fill_lt2;
    logic fill_one;
    logic rd_is_data;
    logic total_gt_fill;
    logic at_check;
    logic check_ok;
    logic plen_zero;
    logic last_item;
    logic out_free;
  } dd_status_t;

  // Payload length from a header byte.
  function automatic logic [TOT_W-1:0] payload_len(input logic [7:0] hdr);
    logic [TOT_W-1:0] len;
    if (hdr[3] == 1'b0) begin
      len = TOT_W'(8) + TOT_W'(hdr & LEN_LOW) + TOT_W'((hdr & LEN_HIGH) >> 1);
    end else begin
      len = TOT_W'(hdr & LEN_LOW);
    end
    return len;
  endfunction

  // Circular window address: base plus offset, wrapped once.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W:0] a,
                                                input logic [IDX_W:0] b);
    logic [IDX_W:0] s;
    s = a + b;
    if (s >= (IDX_W + 1)'(WINDOW_BYTES)) begin
      s = s - (IDX_W + 1)'(WINDOW_BYTES);
    end
    return s[IDX_W-1:0];
  endfunction

  // Saturating add into the drop counter.
  function automatic logic [7:0] drop_add(input logic [7:0] d, input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(d) + SUM_W'(n);
    if (s > SUM_W'(255)) begin
      s = SUM_W'(255);
    end
    return s[7:0];
  endfunction

endpackage

// ===== design/dd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/dd_datapath.sv =====
// Datapath: byte window, pointers, checksum accumulator and result register.
module dd_datapath
  import dd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dd_cmd_t    cmd,
  output dd_status_t status,
  input  logic [7:0] rx_byte,
  input  logic       expected_toggle,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] payload_byte,
  output logic       has_payload,
  output logic       last_item,
  output logic       hold_flag,
  output logic       fault_flag,
  output logic       deliver,
  output logic [7:0] dropped_bytes
);

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] fill;
  logic [7:0]       drop;
  logic             held_hold;
  logic             held_fault;
  logic             cur_hold;
  logic             cur_fault;
  logic             cur_dv;
  logic             tog;
  logic [7:0]       hdr;
  logic [6:0]       sum;
  logic [IDX_W-1:0] k;

  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_off;
  logic [7:0]       rd_data;
  logic             wr_en;
  logic             fill_full;
  logic [TOT_W-1:0] plen_rd;
  logic [TOT_W-1:0] plen;
  logic [TOT_W-1:0] total;
  logic [6:0]       neg_sum;
  logic             nh;
  logic             nf;

  assign fill_full = (fill == CNT_W'(WINDOW_BYTES));
  assign wr_en = cmd.wr_in && !fill_full;
  assign wr_addr = wrap_add({1'b0, head}, (IDX_W + 1)'(fill));

  // Select read offset from the window front
  always_comb begin
    case (cmd.rd_off)
      OFF_ZERO: rd_off = '0;
      OFF_ONE:  rd_off = IDX_W'(1);
      default:  rd_off = k + IDX_W'(1);
    endcase
  end
  assign rd_addr = wrap_add({1'b0, head}, {1'b0, rd_off});

  dd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign plen_rd = payload_len(rd_data);
  assign plen    = payload_len(hdr);
  assign total   = plen + TOT_W'(2);
  assign neg_sum = ~sum + 7'd1;
  assign nh      = hdr[3] ? hdr[4] : held_hold;
  assign nf      = hdr[3] ? hdr[5] : held_fault;

  // Status toward the controller
  always_comb begin
    status.fill_lt2      = (fill < CNT_W'(2));
    status.fill_one      = (fill == CNT_W'(1));
    status.rd_is_data    = rd_data[7];
    status.total_gt_fill = (CNT_W'(plen_rd) + CNT_W'(2) > fill);
    status.at_check      = ({1'b0, k} == (IDX_W + 1)'(total - TOT_W'(1)));
    status.check_ok      = (rd_data == (DATA_MARK | {1'b0, neg_sum})) && (hdr[6] == tog);
    status.plen_zero     = (plen == '0);
    status.last_item     = (plen == '0) || ({1'b0, k} + (IDX_W + 1)'(1) == (IDX_W + 1)'(plen));
    status.out_free      = !out_valid || out_ready;
  end

  // Window pointers, counters and retained flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      drop       <= '0;
      held_hold  <= 1'b0;
      held_fault <= 1'b0;
    end else begin
      if (cmd.wr_in) begin
        if (fill_full) begin
          drop <= drop_add(drop, CNT_W'(1));
        end else begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.discard) begin
        head <= wrap_add({1'b0, head}, (IDX_W + 1)'(1));
        fill <= fill - CNT_W'(1);
        drop <= drop_add(drop, CNT_W'(1));
      end
      if (cmd.accept) begin
        drop <= drop_add(drop, fill - CNT_W'(total));
      end
      if (cmd.finish) begin
        head       <= '0;
        fill       <= '0;
        drop       <= '0;
        held_hold  <= cur_hold;
        held_fault <= cur_fault;
      end
    end
  end

  // Candidate header, checksum and item index
  always_ff @(posedge clk) begin
    if (cmd.wr_in) begin
      tog <= expected_toggle;
    end
    if (cmd.start_sum) begin
      hdr <= rd_data;
      sum <= rd_data[6:0];
      k   <= IDX_W'(1);
    end
    if (cmd.sum_step) begin
      sum <= sum + (rd_data[6:0] & LOW7);
      k   <= k + IDX_W'(1);
    end
    if (cmd.accept) begin
      cur_hold  <= nh;
      cur_fault <= nf;
      cur_dv    <= (plen != '0) || (nh != held_hold) || (nf != held_fault);
      k         <= '0;
    end
    if (cmd.load) begin
      k <= k + IDX_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      payload_byte  <= status.plen_zero ? 7'd0 : rd_data[6:0];
      has_payload   <= !status.plen_zero;
      last_item     <= status.last_item;
      hold_flag     <= cur_hold;
      fault_flag    <= cur_fault;
      deliver       <= cur_dv;
      dropped_bytes <= drop;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW_BYTES))
    else $error("window fill exceeds its depth");

  a_finish_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (fill == '0) && (drop == '0))
    else $error("window not emptied after an accepted datagram");

  a_drop_grows: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.finish)) |-> (drop >= $past(drop)))
    else $error("drop count fell without an accepted datagram");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

// ===== design/dd_ctrl.sv =====
// Controller: sequences store, header scan, checksum walk and payload emission.
module dd_ctrl
  import dd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dd_status_t status,
  output dd_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_off = OFF_ZERO;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_in  = 1'b1;
          state_next = ST_TOP;
        end
      end
      ST_TOP: begin
        if (status.fill_lt2) begin
          state_next = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = OFF_ZERO;
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        if (status.rd_is_data) begin
          cmd.discard = 1'b1;
          if (status.fill_one) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = OFF_ONE;
          end
        end else if (status.fill_lt2 || status.total_gt_fill) begin
          state_next = ST_IDLE;
        end else begin
          cmd.start_sum = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_off    = OFF_ONE;
          state_next    = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!status.at_check) begin
          cmd.sum_step = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_off   = OFF_KNEXT;
        end else if (status.check_ok) begin
          cmd.accept = 1'b1;
          state_next = ST_EMIT_RD;
        end else begin
          cmd.discard = 1'b1;
          state_next  = ST_TOP;
        end
      end
      ST_EMIT_RD: begin
        if (!status.plen_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = OFF_KNEXT;
        end
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (status.last_item) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_TOP))
    else $error("stored byte not followed by a scan");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_in, cmd.discard, cmd.start_sum, cmd.sum_step, cmd.accept, cmd.load}))
    else $error("conflicting datapath commands");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> cmd.load)
    else $error("datagram finished without its last result");
`endif

endmodule

// ===== design/datagram_deframer.sv =====
// Top level of the receive-side datagram deframer.
// Takes one received byte per input transfer into a 64-byte circular window and scans it:
// data bytes ahead of a header are dropped, a header's datagram is checked for its
// 7-bit negated-sum checksum and toggle, and an accepted datagram leaves one result
// transfer per payload byte (one for an empty payload). Each byte is stored, then the
// window is scanned: discarded data bytes one by one and, for each candidate checked,
// its header fetch and then each byte after the header, all walked through the single
// read port of the window RAM; the longest datagram checked is 41 bytes. Emission
// reads and loads each result in turn and holds while the receiver stalls.
// No input is taken until the scan and any emission of that byte are finished.
module datagram_deframer
  import dd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       expected_toggle,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] payload_byte,
  output logic       has_payload,
  output logic       last_item,
  output logic       hold_flag,
  output logic       fault_flag,
  output logic       deliver,
  output logic [7:0] dropped_bytes
);

  dd_cmd_t    cmd;
  dd_status_t status;

  dd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .rx_byte         (rx_byte),
    .expected_toggle (expected_toggle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_byte    (payload_byte),
    .has_payload     (has_payload),
    .last_item       (last_item),
    .hold_flag       (hold_flag),
    .fault_flag      (fault_flag),
    .deliver         (deliver),
    .dropped_bytes   (dropped_bytes)
  );

endmodule
